/* rtl/euler_to_basis_vectors_top_assert.svh */
// Assertion macros used by the checker of this block.
`ifndef EULER_TO_BASIS_VECTORS_TOP_ASSERT_SVH
`define EULER_TO_BASIS_VECTORS_TOP_ASSERT_SVH
// Same-cycle implication, sampled on clk, off during reset.
`define E2B_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define E2B_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/e2b_pkg.sv */
// ----------------------------------------------------------------------------
// e2b_pkg
// Shared types, constants and fixed-point helpers of the Euler-to-basis block.
// ----------------------------------------------------------------------------
package e2b_pkg;

	localparam int ANGLE_BITS_DEF     = 16;
	localparam int COMPONENT_BITS_DEF = 16;
	localparam int CORDIC_STEPS       = 30;
	// 30 rotation stages, fold, two product stages, output stage
	localparam int PIPE_STAGES        = CORDIC_STEPS + 4;

	// Q2.30 with headroom for CORDIC growth
	typedef logic signed [32:0] q30_t;
	// sum of two Q2.30 products
	typedef logic signed [34:0] sum_t;

	localparam q30_t CORDIC_GAIN = 33'sd652032874;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	// Q2.30 product, rounded half up
	function automatic q30_t qmul(input q30_t a, input q30_t b);
		logic signed [65:0] p;
		p = 66'(a) * 66'(b) + 66'sd536870912;
		return p[62:30];
	endfunction

endpackage

/* rtl/e2b_if.sv */
// ----------------------------------------------------------------------------
// e2b_angles_if / e2b_basis_if
// Valid/ready channels for the angle triple and the nine basis components.
// ----------------------------------------------------------------------------
interface e2b_angles_if #(parameter int AW = 16);
	logic          valid;
	logic          ready;
	logic [AW-1:0] pitch_angle;
	logic [AW-1:0] yaw_angle;
	logic [AW-1:0] roll_angle;
	modport source (output valid, pitch_angle, yaw_angle, roll_angle, input ready);
	modport sink   (input valid, pitch_angle, yaw_angle, roll_angle, output ready);
endinterface

interface e2b_basis_if #(parameter int CW = 16);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] fwd_x, fwd_y, fwd_z;
	logic signed [CW-1:0] right_x, right_y, right_z;
	logic signed [CW-1:0] up_x, up_y, up_z;
	modport source (output valid, fwd_x, fwd_y, fwd_z, right_x, right_y, right_z,
		up_x, up_y, up_z, input ready);
	modport sink   (input valid, fwd_x, fwd_y, fwd_z, right_x, right_y, right_z,
		up_x, up_y, up_z, output ready);
endinterface

/* rtl/e2b_cordic.sv */
// ----------------------------------------------------------------------------
// e2b_cordic
// Pipelined rotation-mode CORDIC, one stage per step, then a quadrant fold.
// ----------------------------------------------------------------------------
module e2b_cordic #(
	parameter int ANGLE_BITS = e2b_pkg::ANGLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic [e2b_pkg::CORDIC_STEPS:0] en,
	input  logic [ANGLE_BITS-1:0]          angle,
	output e2b_pkg::q30_t                  sin_o,
	output e2b_pkg::q30_t                  cos_o
);
	import e2b_pkg::*;

	q30_t       x_s [CORDIC_STEPS];
	q30_t       y_s [CORDIC_STEPS];
	q30_t       z_s [CORDIC_STEPS];
	logic [1:0] quad_s [CORDIC_STEPS];
	q30_t       z_init;

	// phase = angle << (32-ANGLE_BITS); low 30 bits are the residual
	assign z_init = q30_t'({angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		q30_t xi, yi, zi, at;
		logic [1:0] qi;
		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = z_init;
			assign qi = angle[ANGLE_BITS-1:ANGLE_BITS-2];
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign qi = quad_s[i-1];
		end
		assign at = q30_t'({1'b0, ATAN_TURNS[i]});
		always_ff @(posedge clk) begin
			if (en[i]) begin
				if (!zi[32]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - at;
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + at;
				end
				quad_s[i] <= qi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[CORDIC_STEPS]) begin
			case (quad_s[CORDIC_STEPS-1])
				2'd0: begin
					sin_o <= y_s[CORDIC_STEPS-1];
					cos_o <= x_s[CORDIC_STEPS-1];
				end
				2'd1: begin
					sin_o <= x_s[CORDIC_STEPS-1];
					cos_o <= -y_s[CORDIC_STEPS-1];
				end
				2'd2: begin
					sin_o <= -y_s[CORDIC_STEPS-1];
					cos_o <= -x_s[CORDIC_STEPS-1];
				end
				default: begin
					sin_o <= -x_s[CORDIC_STEPS-1];
					cos_o <= y_s[CORDIC_STEPS-1];
				end
			endcase
		end
	end

endmodule

/* rtl/e2b_prod.sv */
// ----------------------------------------------------------------------------
// e2b_prod
// Two multiplier stages forming the sine/cosine products of the basis.
// ----------------------------------------------------------------------------
module e2b_prod (
	input  logic          clk,
	input  logic [1:0]    en,
	input  e2b_pkg::q30_t sp, cp, sy, cy, sr, cr,
	output e2b_pkg::q30_t cpcy_s2, cpsy_s2, nsp_s2, srcp_s2, crcp_s2,
	output e2b_pkg::q30_t a_s2, b_s2, c_s2, d_s2, e_s2, f_s2, g_s2, h_s2
);
	import e2b_pkg::*;

	q30_t srsp_s1, crsp_s1, cpcy_s1, cpsy_s1, srcp_s1, crcp_s1;
	q30_t sp_s1, sy_s1, cy_s1, sr_s1, cr_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			srsp_s1 <= qmul(sr, sp);
			crsp_s1 <= qmul(cr, sp);
			cpcy_s1 <= qmul(cp, cy);
			cpsy_s1 <= qmul(cp, sy);
			srcp_s1 <= qmul(sr, cp);
			crcp_s1 <= qmul(cr, cp);
			sp_s1   <= sp;
			sy_s1   <= sy;
			cy_s1   <= cy;
			sr_s1   <= sr;
			cr_s1   <= cr;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cpcy_s2 <= cpcy_s1;
			cpsy_s2 <= cpsy_s1;
			nsp_s2  <= -sp_s1;
			srcp_s2 <= srcp_s1;
			crcp_s2 <= crcp_s1;
			a_s2    <= qmul(srsp_s1, cy_s1);
			b_s2    <= qmul(cr_s1, sy_s1);
			c_s2    <= qmul(srsp_s1, sy_s1);
			d_s2    <= qmul(cr_s1, cy_s1);
			e_s2    <= qmul(crsp_s1, cy_s1);
			f_s2    <= qmul(sr_s1, sy_s1);
			g_s2    <= qmul(crsp_s1, sy_s1);
			h_s2    <= qmul(sr_s1, cy_s1);
		end
	end

endmodule

/* rtl/euler_to_basis_vectors_top.sv */
// Stage order: CORDIC steps, quadrant fold, products, output register.
// Throughput: one transaction per cycle; each stage advances when it is empty
//   or the stage after it advances, so bubbles close up behind a stalled output.
// Reset: arst_n clears only the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// euler_to_basis_vectors_top
// Pitch/yaw/roll binary angles in, forward/right/up unit vectors out in Q1.x.
// ----------------------------------------------------------------------------
module euler_to_basis_vectors_top #(
	parameter int ANGLE_BITS     = e2b_pkg::ANGLE_BITS_DEF,
	parameter int COMPONENT_BITS = e2b_pkg::COMPONENT_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	e2b_angles_if.sink   angles,
	e2b_basis_if.source  basis
);
	import e2b_pkg::*;

	localparam int LAST = PIPE_STAGES - 1;
	// output rounding shift; zero shift means no rounding
	localparam int SH   = (COMPONENT_BITS <= 31) ? 31 - COMPONENT_BITS : 0;
	localparam int RB   = (SH > 0) ? SH - 1 : 0;
	localparam logic signed [35:0] RND = (SH > 0) ? (36'sd1 <<< RB) : 36'sd0;
	localparam logic signed [35:0] HI  = (36'sd1 <<< (COMPONENT_BITS - 1)) - 36'sd1;
	localparam logic signed [35:0] LO  = -(36'sd1 <<< (COMPONENT_BITS - 1));

	// Per-stage valid bits and advance enables.
	// Stage map: 0..29 CORDIC steps, 30 fold, 31..32 products, 33 output.
	logic [LAST:0] vld_q;
	logic [LAST:0] en;

	for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_ctl
		if (k == LAST) begin : g_out
			assign en[k] = !vld_q[k] || basis.ready;
		end else begin : g_mid
			assign en[k] = !vld_q[k] || en[k+1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en[k]) begin
				vld_q[k] <= (k == 0) ? angles.valid : vld_q[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign angles.ready = en[0];
	assign basis.valid  = vld_q[LAST];

	// Three CORDIC lanes share the same stage enables.
	q30_t sp, cp, sy, cy, sr, cr;

	e2b_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_p (
		.clk, .en(en[CORDIC_STEPS:0]), .angle(angles.pitch_angle),
		.sin_o(sp), .cos_o(cp));
	e2b_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_y (
		.clk, .en(en[CORDIC_STEPS:0]), .angle(angles.yaw_angle),
		.sin_o(sy), .cos_o(cy));
	e2b_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_r (
		.clk, .en(en[CORDIC_STEPS:0]), .angle(angles.roll_angle),
		.sin_o(sr), .cos_o(cr));

	q30_t cpcy, cpsy, nsp, srcp, crcp, pa, pb, pc, pd, pe, pf, pg, ph;

	e2b_prod u_prod (
		.clk, .en(en[CORDIC_STEPS+2:CORDIC_STEPS+1]),
		.sp, .cp, .sy, .cy, .sr, .cr,
		.cpcy_s2(cpcy), .cpsy_s2(cpsy), .nsp_s2(nsp), .srcp_s2(srcp), .crcp_s2(crcp),
		.a_s2(pa), .b_s2(pb), .c_s2(pc), .d_s2(pd),
		.e_s2(pe), .f_s2(pf), .g_s2(pg), .h_s2(ph));

	// Round to the output format and clamp.
	function automatic logic signed [COMPONENT_BITS-1:0] to_out(input sum_t v);
		logic signed [35:0] t;
		if (COMPONENT_BITS > 31) begin
			t = 36'(v) <<< 1;
		end else begin
			t = (36'(v) + RND) >>> SH;
		end
		if (t > HI) t = HI;
		if (t < LO) t = LO;
		return t[COMPONENT_BITS-1:0];
	endfunction

	sum_t rx, ry, ux, uy;
	assign rx = sum_t'(pb) - sum_t'(pa);
	assign ry = -sum_t'(pc) - sum_t'(pd);
	assign ux = sum_t'(pe) + sum_t'(pf);
	assign uy = sum_t'(pg) - sum_t'(ph);

	always_ff @(posedge clk) begin
		if (en[LAST]) begin
			basis.fwd_x   <= to_out(sum_t'(cpcy));
			basis.fwd_y   <= to_out(sum_t'(cpsy));
			basis.fwd_z   <= to_out(sum_t'(nsp));
			basis.right_x <= to_out(rx);
			basis.right_y <= to_out(ry);
			basis.right_z <= to_out(-sum_t'(srcp));
			basis.up_x    <= to_out(ux);
			basis.up_y    <= to_out(uy);
			basis.up_z    <= to_out(sum_t'(crcp));
		end
	end

endmodule

/* rtl/e2b_checker.sv */
// ----------------------------------------------------------------------------
// e2b_checker
// Port-level checks of the basis pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "euler_to_basis_vectors_top_assert.svh"

module e2b_checker #(
	parameter int CW = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic [9*CW-1:0] out_data
);
	// a taken output frees every stage, so the input side must be open
	`E2B_ASSERT_NOW(a_ready_chain, out_ready, in_ready, "input stalled while output drains")
	// the pipeline is empty right after reset
	`E2B_ASSERT_NOW(a_empty_after_reset, $rose(arst_n), !out_valid, "valid out of reset")
	`E2B_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid, "valid dropped")
	`E2B_ASSERT_NEXT(a_data_hold, out_valid && !out_ready, $stable(out_data), "data moved")
endmodule

bind euler_to_basis_vectors_top e2b_checker #(.CW(COMPONENT_BITS)) u_e2b_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (angles.ready),
	.out_valid (basis.valid),
	.out_ready (basis.ready),
	.out_data  ({basis.fwd_x, basis.fwd_y, basis.fwd_z, basis.right_x, basis.right_y,
		basis.right_z, basis.up_x, basis.up_y, basis.up_z})
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for euler_to_basis_vectors_top: angle triples go in on
// a valid/ready channel, and every basis transaction is compared field by
// field against typed-in values or a fixed-point CORDIC predictor in the bench.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import e2b_pkg::*;

	localparam int AW         = 16;
	localparam int CW         = 16;
	localparam int RAND_ITEMS = 400;
	localparam int IDLE_LIMIT = 5000;  // cycles with no transaction on either side
	localparam int DRAIN      = 40;    // pipeline is 34 deep
	localparam int MAX_SHOWN  = 10;

	typedef logic signed [CW-1:0] comp_t;
	typedef comp_t basis_vec_t [9];

	// one directed row: angles, and a typed-in basis where it is obvious
	typedef struct {
		logic [AW-1:0] pitch;
		logic [AW-1:0] yaw;
		logic [AW-1:0] roll;
		bit            typed;
		basis_vec_t    basis;
	} angle_row_t;

	typedef struct {
		basis_vec_t basis;
	} basis_entry_t;

	localparam comp_t CMAX  = 16'sh7FFF;
	localparam comp_t CMIN  = -16'sh8000;
	localparam comp_t CZERO = 16'sh0000;

	logic clk;
	logic arst_n;

	e2b_angles_if #(.AW(AW)) angles ();
	e2b_basis_if  #(.CW(CW)) basis ();

	euler_to_basis_vectors_top #(
		.ANGLE_BITS(AW),
		.COMPONENT_BITS(CW)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.angles(angles.sink),
		.basis (basis.source)
	);

	basis_entry_t pending_basis[$];
	int           mismatch_cnt;
	int           basis_seen;
	int           angles_sent;
	int           idle_cycles;
	bit           drain_done;

	string comp_name [9] = '{"fwd_x", "fwd_y", "fwd_z", "right_x", "right_y",
		"right_z", "up_x", "up_y", "up_z"};

	// 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Predictor: quadrant fold plus 30-step rotation CORDIC in Q2.30
	// ------------------------------------------------------------------
	task automatic sincos_fixed(input logic [AW-1:0] ang, output longint s,
		output longint c);
		logic [31:0] phase;
		longint      x, y, z, dx, dy;
		phase = {ang, {(32-AW){1'b0}}};
		x = 652032874;
		y = 0;
		z = longint'(phase[29:0]);
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ATAN_TURNS[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ATAN_TURNS[i]);
			end
		end
		case (phase[31:30])
			2'd0: begin s = y; c = x; end
			2'd1: begin s = x; c = -y; end
			2'd2: begin s = -y; c = -x; end
			default: begin s = -x; c = y; end
		endcase
	endtask

	// Q2.30 product, round half up (>>> floors)
	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// Q2.30 to Q1.15 with rounding and saturation
	function automatic comp_t to_q15(input longint v);
		longint r;
		r = (v + (64'sd1 <<< (30 - CW))) >>> (31 - CW);
		if (r > longint'(CMAX))
			r = longint'(CMAX);
		if (r < longint'(CMIN))
			r = longint'(CMIN);
		return comp_t'(r);
	endfunction

	task automatic orient_to_basis(input logic [AW-1:0] p, input logic [AW-1:0] yw,
		input logic [AW-1:0] r, output basis_vec_t b);
		longint sp, cp, sy, cy, sr, cr, srsp, crsp;
		sincos_fixed(p, sp, cp);
		sincos_fixed(yw, sy, cy);
		sincos_fixed(r, sr, cr);
		srsp = q30_mul(sr, sp);
		crsp = q30_mul(cr, sp);
		b[0] = to_q15(q30_mul(cp, cy));
		b[1] = to_q15(q30_mul(cp, sy));
		b[2] = to_q15(-sp);
		b[3] = to_q15(-q30_mul(srsp, cy) + q30_mul(cr, sy));
		b[4] = to_q15(-q30_mul(srsp, sy) - q30_mul(cr, cy));
		b[5] = to_q15(-q30_mul(sr, cp));
		b[6] = to_q15(q30_mul(crsp, cy) + q30_mul(sr, sy));
		b[7] = to_q15(q30_mul(crsp, sy) - q30_mul(sr, cy));
		b[8] = to_q15(q30_mul(cr, cp));
	endtask

	// ------------------------------------------------------------------
	// Sender: optional gap, then hold the transaction until it is taken.
	// Entered and left at a falling edge.
	// ------------------------------------------------------------------
	function automatic int gap_len();
		// mostly short gaps, now and then a long one
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 3);
	endfunction

	task automatic send_angles(input angle_row_t row, input bit allow_gap);
		basis_entry_t e;
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			angles.valid <= 1'b0;
			repeat (gap_len()) @(negedge clk);
		end
		angles.valid       <= 1'b1;
		angles.pitch_angle <= row.pitch;
		angles.yaw_angle   <= row.yaw;
		angles.roll_angle  <= row.roll;
		@(posedge clk);
		while (!angles.ready)
			@(posedge clk);
		// transaction taken at this edge
		if (row.typed)
			e.basis = row.basis;
		else
			orient_to_basis(row.pitch, row.yaw, row.roll, e.basis);
		pending_basis.push_back(e);
		angles_sent++;
		@(negedge clk);
	endtask

	// angles near a quadrant edge, at an extreme, or anywhere
	function automatic logic [AW-1:0] pick_angle();
		case ($urandom_range(0, 5))
			0: return AW'($urandom_range(0, 3) * 16384 + $urandom_range(0, 6) - 3);
			1: return $urandom_range(0, 1) ? '1 : '0;
			default: return AW'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random back-pressure, with stretches of none
	// ------------------------------------------------------------------
	int stall_left;
	int calm_left;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis.ready <= 1'b0;
			stall_left  <= 0;
			calm_left   <= 0;
		end else if (calm_left > 0) begin
			calm_left   <= calm_left - 1;
			basis.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left  <= stall_left - 1;
			basis.ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 19))
				0: begin
					calm_left   <= $urandom_range(50, 150);
					basis.ready <= 1'b1;
				end
				1: begin
					stall_left  <= $urandom_range(10, 60);
					basis.ready <= 1'b0;
				end
				2, 3, 4: begin
					stall_left  <= $urandom_range(0, 2);
					basis.ready <= 1'b0;
				end
				default: basis.ready <= 1'b1;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Checker: sampled at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		basis_vec_t   got;
		basis_entry_t e;
		bit           bad;
		if (arst_n && basis.valid && basis.ready) begin
			got = '{basis.fwd_x, basis.fwd_y, basis.fwd_z, basis.right_x,
				basis.right_y, basis.right_z, basis.up_x, basis.up_y, basis.up_z};
			basis_seen++;
			if (pending_basis.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_SHOWN)
					$display("ERROR: basis transaction %0d with nothing expected",
						basis_seen);
			end else begin
				e   = pending_basis.pop_front();
				bad = 1'b0;
				for (int i = 0; i < 9; i++) begin
					if (got[i] !== e.basis[i]) begin
						bad = 1'b1;
						if (mismatch_cnt < MAX_SHOWN)
							$display("ERROR: basis %0d %s expected %0d got %0d",
								basis_seen, comp_name[i], e.basis[i], got[i]);
					end
				end
				if (bad)
					mismatch_cnt++;
			end
		end
	end

	// Watchdog: a stuck handshake on either side ends the run
	always @(posedge clk) begin
		if (!arst_n || (angles.valid && angles.ready) || (basis.valid && basis.ready)
			|| drain_done)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Directed rows. Typed values: zero and quarter-turn orientations
	// give exact unit axes (saturated at +1.0).
	// ------------------------------------------------------------------
	angle_row_t directed [$];

	function automatic angle_row_t mk_row(input logic [AW-1:0] p, input logic [AW-1:0] yw,
		input logic [AW-1:0] r);
		angle_row_t row;
		row.pitch = p;
		row.yaw   = yw;
		row.roll  = r;
		row.typed = 1'b0;
		row.basis = '{default: CZERO};
		return row;
	endfunction

	initial begin
		angle_row_t row;
		int         n;

		arst_n             = 1'b0;
		angles.valid       = 1'b0;
		angles.pitch_angle = '0;
		angles.yaw_angle   = '0;
		angles.roll_angle  = '0;
		mismatch_cnt       = 0;
		basis_seen         = 0;
		angles_sent        = 0;
		drain_done         = 1'b0;

		// identity orientation
		row       = mk_row(16'h0000, 16'h0000, 16'h0000);
		row.typed = 1'b1;
		row.basis = '{CMAX, CZERO, CZERO, CZERO, CMIN, CZERO, CZERO, CZERO, CMAX};
		directed.push_back(row);
		// pitch straight up: forward z goes to -1
		row       = mk_row(16'h4000, 16'h0000, 16'h0000);
		row.typed = 1'b1;
		row.basis = '{CZERO, CZERO, CMIN, CZERO, CMIN, CZERO, CMAX, CZERO, CZERO};
		directed.push_back(row);
		// extremes and quadrant edges of every field, then mixed poses
		directed.push_back(mk_row(16'hFFFF, 16'hFFFF, 16'hFFFF));
		directed.push_back(mk_row(16'h8000, 16'h0000, 16'h0000));
		directed.push_back(mk_row(16'hC000, 16'h0000, 16'h0000));
		directed.push_back(mk_row(16'h0000, 16'h4000, 16'h0000));
		directed.push_back(mk_row(16'h0000, 16'h8000, 16'h0000));
		directed.push_back(mk_row(16'h0000, 16'hC000, 16'h0000));
		directed.push_back(mk_row(16'h0000, 16'h0000, 16'h4000));
		directed.push_back(mk_row(16'h0000, 16'h0000, 16'h8000));
		directed.push_back(mk_row(16'h0000, 16'h0000, 16'hC000));
		directed.push_back(mk_row(16'h2000, 16'h2000, 16'h2000));
		directed.push_back(mk_row(16'h3FFF, 16'h4001, 16'hBFFF));
		directed.push_back(mk_row(16'h0001, 16'h7FFF, 16'h8001));
		directed.push_back(mk_row(16'hFFFF, 16'h0000, 16'hFFFF));
		directed.push_back(mk_row(16'h5555, 16'hAAAA, 16'h1234));
		directed.push_back(mk_row(16'hAAAA, 16'h5555, 16'hEDCB));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows back to back, no sender gaps
		foreach (directed[i])
			send_angles(directed[i], 1'b0);

		// random part; midway the sender holds off until the pipe is empty
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 2) begin
				angles.valid <= 1'b0;
				while (pending_basis.size() != 0)
					@(negedge clk);
			end
			send_angles(mk_row(pick_angle(), pick_angle(), pick_angle()),
				(n % 100) >= 30);
		end
		angles.valid <= 1'b0;

		while (pending_basis.size() != 0)
			@(negedge clk);
		drain_done = 1'b1;
		repeat (DRAIN) @(negedge clk);

		$display("sent %0d angle triples (%0d directed), checked %0d basis results",
			angles_sent, directed.size(), basis_seen);
		$display("quadrant edges, full-scale angles and random poses under back-pressure");
		if (mismatch_cnt == 0 && pending_basis.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* euler_to_basis_vectors_top.f */
+incdir+rtl
rtl/e2b_pkg.sv
rtl/e2b_if.sv
rtl/e2b_cordic.sv
rtl/e2b_prod.sv
rtl/euler_to_basis_vectors_top.sv
rtl/e2b_checker.sv
tb/testbench.sv
